### rtl/lbrf_pkg.sv
// Shared types and constants for the line-buffered receive ring.
// No dependencies; imported by lbrf_ring and line_buffered_rx_fifo_top.
package lbrf_pkg;

  localparam logic [7:0] NEWLINE = 8'h0A;

  localparam logic MODE_RX   = 1'b0;
  localparam logic MODE_READ = 1'b1;

  localparam logic [1:0] STATUS_BYTE   = 2'd0;
  localparam logic [1:0] STATUS_REJECT = 2'd1;
  localparam logic [1:0] STATUS_EMPTY  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EMIT
  } state_t;

endpackage

### rtl/lbrf_ring.sv
// Byte ring storage: one write port, one registered read port.
// Per-entry valid bits make unwritten entries read as zero after reset.
// Depends on lbrf_pkg.
module lbrf_ring
  import lbrf_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int PW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [PW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [PW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [7:0]       rd_raw;
  logic             rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_raw <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      rd_valid <= valid[rd_addr];
    end
  end

  assign rd_data = rd_valid ? rd_raw : 8'h00;

endmodule

### rtl/line_buffered_rx_fifo_top.sv
// Top level of the line-buffered receive ring: command port, sequencer, pointers.
// Depends on lbrf_pkg and lbrf_ring.
//
// Usage: present mode, rx_byte and read_size with start high; the item is taken
// at a clock edge where start is high and busy is low.
// mode 0 stores rx_byte and produces no result. When the ring is
// full or an overflow is pending, a newline is forced into the write slot and
// the line count still advances.
// mode 1 reads one line. A rejected read (read_size above DEPTH or no line
// counted) or a read of an empty ring gives one result, on strobe, in the
// cycle after the item is taken. Otherwise the sequencer loops over the ring
// through the single read port, visiting FETCH (address) and then EMIT (data)
// for each byte, so busy stays high until the line ends and its bytes appear
// on strobe one at a time, the last one marked by is_last.
// Results are held for exactly one cycle; the receiver cannot stall them.
// Reset (synchronous, rst high) clears pointers, line count, the overflow flag
// and the per-entry valid bits, so the ring reads as all zeros.
module line_buffered_rx_fifo_top
  import lbrf_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       mode,
  input  logic [7:0] rx_byte,
  input  logic [7:0] read_size,
  output logic       strobe,
  output logic [7:0] data_byte,
  output logic [1:0] status,
  output logic       is_last
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] MAX_BYTES = CW'(DEPTH);

  state_t        state, state_next;
  logic [PW-1:0] wp, wp_next;
  logic [PW-1:0] rp, rp_next;
  logic [7:0]    line_count, line_count_next;
  logic          ovf, ovf_next;
  logic [CW-1:0] cnt, cnt_next;

  logic          strobe_next;
  logic [7:0]    data_byte_next;
  logic [1:0]    status_next;
  logic          is_last_next;

  logic          wr_en;
  logic [7:0]    wr_data;
  logic [7:0]    rd_data;

  logic          accept;
  logic          reject;
  logic [PW-1:0] wp_inc, rp_inc;
  logic          line_end;

  function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
    return (p == LAST_SLOT) ? '0 : p + PW'(1);
  endfunction

  lbrf_ring #(
    .DEPTH (DEPTH),
    .PW    (PW)
  ) u_ring (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (wp),
    .wr_data (wr_data),
    .rd_addr (rp),
    .rd_data (rd_data)
  );

  assign accept = start && (state == ST_IDLE);
  assign reject = ({1'b0, read_size} > 9'(DEPTH)) || (line_count == 8'd0);
  assign wp_inc = next_slot(wp);
  assign rp_inc = next_slot(rp);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && mode == MODE_READ && !reject && wp != rp) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: state_next = ST_EMIT;
      ST_EMIT: begin
        if (line_end) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_FETCH;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath and result outputs
  always_comb begin
    wp_next         = wp;
    rp_next         = rp;
    line_count_next = line_count;
    ovf_next        = ovf;
    cnt_next        = cnt;
    wr_en           = 1'b0;
    wr_data         = rx_byte;
    strobe_next     = 1'b0;
    data_byte_next  = 8'h00;
    status_next     = STATUS_BYTE;
    is_last_next    = 1'b0;
    line_end        = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept && mode == MODE_RX) begin
          wr_en = 1'b1;
          if (wp_inc != rp && !ovf) begin
            wp_next = wp_inc;
            if (rx_byte == NEWLINE) begin
              line_count_next = line_count + 8'd1;
            end
          end else begin
            // force a line end into the held slot
            wr_data         = NEWLINE;
            line_count_next = line_count + 8'd1;
            ovf_next        = 1'b1;
          end
        end else if (accept && mode == MODE_READ) begin
          if (reject) begin
            strobe_next  = 1'b1;
            status_next  = STATUS_REJECT;
            is_last_next = 1'b1;
          end else begin
            line_count_next = line_count - 8'd1;
            cnt_next        = '0;
            if (wp == rp) begin
              strobe_next  = 1'b1;
              status_next  = STATUS_EMPTY;
              is_last_next = 1'b1;
            end
          end
        end
      end
      ST_FETCH: begin
      end
      ST_EMIT: begin
        strobe_next    = 1'b1;
        data_byte_next = rd_data;
        rp_next        = rp_inc;
        cnt_next       = cnt + CW'(1);
        if (rd_data != NEWLINE && ovf) begin
          // step past the forced line end
          ovf_next = 1'b0;
          wp_next  = wp_inc;
        end
        line_end = (rd_data == NEWLINE) || (rp_next == wp_next) ||
                   (cnt_next == MAX_BYTES);
        is_last_next = line_end;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      wp         <= '0;
      rp         <= '0;
      line_count <= 8'd0;
      ovf        <= 1'b0;
      cnt        <= '0;
      strobe     <= 1'b0;
    end else begin
      state      <= state_next;
      wp         <= wp_next;
      rp         <= rp_next;
      line_count <= line_count_next;
      ovf        <= ovf_next;
      cnt        <= cnt_next;
      strobe     <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    data_byte <= data_byte_next;
    status    <= status_next;
    is_last   <= is_last_next;
  end

  assign busy = (state != ST_IDLE);

endmodule
